// ----- rtl/cac_pkg.sv -----
// ----------------------------------------------------------------------------
// cac_pkg
// Shared types, codes and constants of the compartment alarm controller.
// ----------------------------------------------------------------------------
package cac_pkg;

  localparam int COMPARTMENTS = 4;
  localparam int QUEUE_DEPTH  = 4;
  localparam int MAX_RESULTS  = 8;
  localparam int CNT_W        = $clog2(MAX_RESULTS);
  localparam int THR_W        = 27;
  localparam int STATUS_W     = 9;

  localparam logic [15:0] MS_PER_MIN = 16'd60000;

  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_TEST  = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  localparam logic [2:0] EV_NONE      = 3'd0;
  localparam logic [2:0] EV_ON_TIME   = 3'd1;
  localparam logic [2:0] EV_OFF_SCHED = 3'd2;
  localparam logic [2:0] EV_MISSED    = 3'd3;
  localparam logic [2:0] EV_DUE       = 3'd4;

  localparam logic [2:0] REG_ENABLE_MASK   = 3'd0;
  localparam logic [2:0] REG_MISSED_WINDOW = 3'd1;
  localparam logic [2:0] REG_TEST_DURATION = 3'd2;
  localparam logic [2:0] REG_LED_ON        = 3'd3;
  localparam logic [2:0] REG_LED_OFF       = 3'd4;
  localparam logic [2:0] REG_BUZZER_ON     = 3'd5;
  localparam logic [2:0] REG_BUZZER_OFF    = 3'd6;

  localparam logic [3:0]       RST_ENABLE_MASK   = 4'd15;
  localparam logic [THR_W-1:0] RST_MISSED_THR    = 27'd1800000;
  localparam logic [31:0]      RST_TEST_DURATION = 32'd10000;
  localparam logic [15:0]      RST_LED_ON        = 16'd500;
  localparam logic [15:0]      RST_LED_OFF       = 16'd500;
  localparam logic [15:0]      RST_BUZZER_ON     = 16'd200;
  localparam logic [15:0]      RST_BUZZER_OFF    = 16'd200;

  typedef struct packed {
    logic [3:0] led;
    logic       buzzer;
    logic [3:0] alarm;
  } status_t;

  typedef struct packed {
    logic [3:0]       enable_mask;
    logic [THR_W-1:0] missed_thr_ms;
    logic [31:0]      test_duration_ms;
    logic [15:0]      led_on_ms;
    logic [15:0]      led_off_ms;
    logic [15:0]      buzzer_on_ms;
    logic [15:0]      buzzer_off_ms;
  } cfg_t;

endpackage

// ----- rtl/cac_queue.sv -----
// ----------------------------------------------------------------------------
// cac_queue
// Small first-in first-out buffer between the request front and the event back.
// ----------------------------------------------------------------------------
module cac_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = cac_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             rd,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/cac_front.sv -----
// ----------------------------------------------------------------------------
// cac_front
// Takes requests, updates every compartment in parallel on a tick (a test or a clear
// touches only the named one) and queues a record of the events and status caused.
// ----------------------------------------------------------------------------
module cac_front #(
  parameter int COMPARTMENTS = cac_pkg::COMPARTMENTS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cac_pkg::cfg_t        cfg,
  input  logic                 push,
  input  logic                 q_full,
  input  logic [1:0]           req_type,
  input  logic [1:0]           compartment,
  input  logic [31:0]          now_ms,
  input  logic [15:0]          day_number,
  input  logic [3:0]           present_mask,
  input  logic [3:0]           removed_mask,
  input  logic [3:0]           window_mask,
  output logic                 rec_wr,
  output logic [5*COMPARTMENTS+cac_pkg::STATUS_W-1:0] rec
);

  localparam int C    = COMPARTMENTS;
  localparam int PADW = (C > 4) ? C : 4;

  logic [C-1:0] alarming;
  logic [C-1:0] test_active;
  logic [C-1:0] led_lit;
  logic [31:0]  test_start_ms [C];
  logic [31:0]  alarm_start_ms [C];
  logic [31:0]  led_toggle_ms [C];
  logic [15:0]  handled_day [C];
  logic         buzzer_lit;
  logic [31:0]  buzzer_toggle_ms;

  logic [C-1:0] alarming_next;
  logic [C-1:0] test_active_next;
  logic [C-1:0] led_lit_next;
  logic [31:0]  test_start_ms_next [C];
  logic [31:0]  alarm_start_ms_next [C];
  logic [31:0]  led_toggle_ms_next [C];
  logic [15:0]  handled_day_next [C];
  logic         buzzer_lit_next;
  logic [31:0]  buzzer_toggle_ms_next;

  logic [C-1:0][2:0] ev1;
  logic [2*C-1:0]    slots;
  logic [PADW-1:0]   en_pad, pres_pad, rem_pad, win_pad;
  logic [PADW-1:0]   led_pad, alarm_pad;
  logic              tick;
  logic              any;
  logic [15:0]       iv;
  logic [15:0]       biv;
  cac_pkg::status_t  status;

  assign rec_wr   = push && !q_full;
  assign tick     = (req_type == cac_pkg::REQ_TICK);
  assign en_pad   = PADW'(cfg.enable_mask);
  assign pres_pad = PADW'(present_mask);
  assign rem_pad  = PADW'(removed_mask);
  assign win_pad  = PADW'(window_mask);

  always_comb begin
    alarming_next         = alarming;
    test_active_next      = test_active;
    led_lit_next          = led_lit;
    test_start_ms_next    = test_start_ms;
    alarm_start_ms_next   = alarm_start_ms;
    led_toggle_ms_next    = led_toggle_ms;
    handled_day_next      = handled_day;
    buzzer_lit_next       = buzzer_lit;
    buzzer_toggle_ms_next = buzzer_toggle_ms;
    ev1   = '0;
    slots = '0;
    any   = 1'b0;
    iv    = '0;
    biv   = '0;
    for (int i = 0; i < C; i++) begin
      if (tick) begin
        if (test_active[i]) begin
          if ((now_ms - test_start_ms[i]) > cfg.test_duration_ms) begin
            test_active_next[i] = 1'b0;
            alarming_next[i]    = 1'b0;
          end
        end else begin
          if (rem_pad[i] && alarming[i]) begin
            alarming_next[i]    = 1'b0;
            handled_day_next[i] = day_number;
            ev1[i]              = cac_pkg::EV_ON_TIME;
          end else if (rem_pad[i]) begin
            ev1[i] = cac_pkg::EV_OFF_SCHED;
          end
          if (alarming_next[i] &&
              (now_ms - alarm_start_ms[i]) >= 32'(cfg.missed_thr_ms)) begin
            alarming_next[i]    = 1'b0;
            handled_day_next[i] = day_number;
            ev1[i]              = cac_pkg::EV_MISSED;
          end
          if (en_pad[i] && !alarming_next[i] && pres_pad[i] && win_pad[i] &&
              handled_day_next[i] != day_number) begin
            alarming_next[i]       = 1'b1;
            alarm_start_ms_next[i] = now_ms;
            slots[2*i+1]           = 1'b1;
          end
          slots[2*i] = (ev1[i] != cac_pkg::EV_NONE);
        end
        if (alarming_next[i] || test_active_next[i]) begin
          any = 1'b1;
          iv  = led_lit[i] ? cfg.led_on_ms : cfg.led_off_ms;
          if ((now_ms - led_toggle_ms[i]) >= 32'(iv)) begin
            led_lit_next[i]       = !led_lit[i];
            led_toggle_ms_next[i] = now_ms;
          end
        end else begin
          led_lit_next[i] = 1'b0;
        end
      end else if (req_type == cac_pkg::REQ_TEST && int'(compartment) == i) begin
        test_active_next[i]   = 1'b1;
        test_start_ms_next[i] = now_ms;
        alarming_next[i]      = 1'b1;
      end else if (req_type == cac_pkg::REQ_CLEAR && int'(compartment) == i) begin
        handled_day_next[i] = '0;
      end
    end
    if (tick) begin
      if (any) begin
        biv = buzzer_lit ? cfg.buzzer_on_ms : cfg.buzzer_off_ms;
        if ((now_ms - buzzer_toggle_ms) >= 32'(biv)) begin
          buzzer_lit_next       = !buzzer_lit;
          buzzer_toggle_ms_next = now_ms;
        end
      end else begin
        buzzer_lit_next = 1'b0;
      end
    end
  end

  assign led_pad       = PADW'(led_lit_next);
  assign alarm_pad     = PADW'(alarming_next);
  assign status.led    = led_pad[3:0];
  assign status.buzzer = buzzer_lit_next;
  assign status.alarm  = alarm_pad[3:0];
  assign rec           = {ev1, slots, status};

  always_ff @(posedge clk) begin
    if (rst) begin
      alarming         <= '0;
      test_active      <= '0;
      led_lit          <= '0;
      buzzer_lit       <= 1'b0;
      buzzer_toggle_ms <= '0;
      for (int i = 0; i < C; i++) begin
        test_start_ms[i]  <= '0;
        alarm_start_ms[i] <= '0;
        led_toggle_ms[i]  <= '0;
        handled_day[i]    <= '0;
      end
    end else if (rec_wr) begin
      alarming         <= alarming_next;
      test_active      <= test_active_next;
      led_lit          <= led_lit_next;
      test_start_ms    <= test_start_ms_next;
      alarm_start_ms   <= alarm_start_ms_next;
      led_toggle_ms    <= led_toggle_ms_next;
      handled_day      <= handled_day_next;
      buzzer_lit       <= buzzer_lit_next;
      buzzer_toggle_ms <= buzzer_toggle_ms_next;
    end
  end

endmodule

// ----- rtl/cac_back.sv -----
// ----------------------------------------------------------------------------
// cac_back
// Takes queued records and hands out their events one result at a time,
// in compartment order, with the status fields on every result.
// ----------------------------------------------------------------------------
module cac_back #(
  parameter int COMPARTMENTS = cac_pkg::COMPARTMENTS
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_empty,
  input  logic [5*COMPARTMENTS+cac_pkg::STATUS_W-1:0] q_rdata,
  output logic       q_rd,
  output logic       empty,
  input  logic       pop,
  output logic [1:0] event_compartment,
  output logic [2:0] event_code,
  output logic [3:0] led_mask,
  output logic       buzzer,
  output logic [3:0] alarm_mask,
  output logic       last
);

  localparam int C = COMPARTMENTS;
  localparam int S = 2 * C;

  logic                      cur_valid;
  logic [3*C-1:0]            cur_ev;
  logic [S-1:0]              cur_rem;
  cac_pkg::status_t          cur_status;
  logic [cac_pkg::CNT_W-1:0] cnt;

  logic [S-1:0] rem_rest;
  logic         take;
  logic         load;

  assign empty    = !cur_valid;
  assign take     = pop && cur_valid;
  assign rem_rest = cur_rem & (cur_rem - 1'b1);
  assign last     = (rem_rest == '0) || (cnt == cac_pkg::CNT_W'(cac_pkg::MAX_RESULTS - 1));
  assign load     = !q_empty && (!cur_valid || (take && last));
  assign q_rd     = load;

  assign led_mask   = cur_status.led;
  assign buzzer     = cur_status.buzzer;
  assign alarm_mask = cur_status.alarm;

  always_comb begin
    event_compartment = '0;
    event_code        = cac_pkg::EV_NONE;
    for (int j = S - 1; j >= 0; j--) begin
      if (cur_rem[j]) begin
        event_compartment = 2'(j / 2);
        event_code        = (j % 2 == 1) ? cac_pkg::EV_DUE : cur_ev[(j/2)*3 +: 3];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur_ev     <= q_rdata[S+cac_pkg::STATUS_W +: 3*C];
      cur_rem    <= q_rdata[cac_pkg::STATUS_W +: S];
      cur_status <= q_rdata[cac_pkg::STATUS_W-1:0];
    end else if (take && !last) begin
      cur_rem <= rem_rest;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      cnt       <= '0;
    end else if (load) begin
      cur_valid <= 1'b1;
      cnt       <= '0;
    end else if (take) begin
      if (last) begin
        cur_valid <= 1'b0;
      end else begin
        cnt <= cnt + 1'b1;
      end
    end
  end

endmodule

// ----- rtl/compartment_alarm_controller_top.sv -----
// a taken request is queued, then loaded by the back when free, which shows its first result
// requests are taken one per cycle while the queue is not full; results leave one per pop
// a four-entry queue between front and back lets each side stall on its own
// reset: synchronous rst clears all compartment state and loads register defaults
// ----------------------------------------------------------------------------
// compartment_alarm_controller_top
// Per-compartment medicine alarm controller with blinking LEDs and a buzzer.
// ----------------------------------------------------------------------------
module compartment_alarm_controller_top #(
  parameter int COMPARTMENTS = cac_pkg::COMPARTMENTS,
  parameter int QUEUE_DEPTH  = cac_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_addr,
  input  logic [31:0] cfg_wdata,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  req_type,
  input  logic [1:0]  compartment,
  input  logic [31:0] now_ms,
  input  logic [15:0] day_number,
  input  logic [3:0]  present_mask,
  input  logic [3:0]  removed_mask,
  input  logic [3:0]  window_mask,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  event_compartment,
  output logic [2:0]  event_code,
  output logic [3:0]  led_mask,
  output logic        buzzer,
  output logic [3:0]  alarm_mask,
  output logic        last
);

  localparam int REC_W = 5 * COMPARTMENTS + cac_pkg::STATUS_W;

  cac_pkg::cfg_t    cfg;
  logic             rec_wr;
  logic [REC_W-1:0] rec;
  logic             q_rd;
  logic             q_empty;
  logic [REC_W-1:0] q_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable_mask      <= cac_pkg::RST_ENABLE_MASK;
      cfg.missed_thr_ms    <= cac_pkg::RST_MISSED_THR;
      cfg.test_duration_ms <= cac_pkg::RST_TEST_DURATION;
      cfg.led_on_ms        <= cac_pkg::RST_LED_ON;
      cfg.led_off_ms       <= cac_pkg::RST_LED_OFF;
      cfg.buzzer_on_ms     <= cac_pkg::RST_BUZZER_ON;
      cfg.buzzer_off_ms    <= cac_pkg::RST_BUZZER_OFF;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        cac_pkg::REG_ENABLE_MASK: begin
          cfg.enable_mask <= cfg_wdata[3:0];
        end
        cac_pkg::REG_MISSED_WINDOW: begin
          cfg.missed_thr_ms <= cac_pkg::THR_W'(cac_pkg::THR_W'(cfg_wdata[10:0]) *
                                               cac_pkg::THR_W'(cac_pkg::MS_PER_MIN));
        end
        cac_pkg::REG_TEST_DURATION: begin
          cfg.test_duration_ms <= cfg_wdata;
        end
        cac_pkg::REG_LED_ON: begin
          cfg.led_on_ms <= cfg_wdata[15:0];
        end
        cac_pkg::REG_LED_OFF: begin
          cfg.led_off_ms <= cfg_wdata[15:0];
        end
        cac_pkg::REG_BUZZER_ON: begin
          cfg.buzzer_on_ms <= cfg_wdata[15:0];
        end
        cac_pkg::REG_BUZZER_OFF: begin
          cfg.buzzer_off_ms <= cfg_wdata[15:0];
        end
        default: begin
        end
      endcase
    end
  end

  cac_front #(
    .COMPARTMENTS(COMPARTMENTS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .push         (push),
    .q_full       (full),
    .req_type     (req_type),
    .compartment  (compartment),
    .now_ms       (now_ms),
    .day_number   (day_number),
    .present_mask (present_mask),
    .removed_mask (removed_mask),
    .window_mask  (window_mask),
    .rec_wr       (rec_wr),
    .rec          (rec)
  );

  cac_queue #(
    .WIDTH(REC_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (rec_wr),
    .wdata (rec),
    .full  (full),
    .rd    (q_rd),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  cac_back #(
    .COMPARTMENTS(COMPARTMENTS)
  ) u_back (
    .clk               (clk),
    .rst               (rst),
    .q_empty           (q_empty),
    .q_rdata           (q_rdata),
    .q_rd              (q_rd),
    .empty             (empty),
    .pop               (pop),
    .event_compartment (event_compartment),
    .event_code        (event_code),
    .led_mask          (led_mask),
    .buzzer            (buzzer),
    .alarm_mask        (alarm_mask),
    .last              (last)
  );

endmodule
